### src/tlex_pkg.sv
// ============================================================================
// tlex_pkg
// Shared types, token kind codes, character codes and keyword table for the
// streaming token lexer.
// ============================================================================
package tlex_pkg;

    // Scanner modes
    typedef enum logic [3:0] {
        M_IDLE  = 4'd0,
        M_IDENT = 4'd1,
        M_INT   = 4'd2,
        M_DOT   = 4'd3,
        M_FRAC  = 4'd4,
        M_STR   = 4'd5,
        M_CMT   = 4'd6,
        M_SLASH = 4'd7,
        M_BANG  = 4'd8,
        M_EQ    = 4'd9,
        M_GT    = 4'd10,
        M_LT    = 4'd11
    } mode_t;

    // Queue status seen by the scanner and the output stage
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // Token kinds
    localparam logic [5:0] K_LPAREN  = 6'd0;
    localparam logic [5:0] K_RPAREN  = 6'd1;
    localparam logic [5:0] K_LBRACE  = 6'd2;
    localparam logic [5:0] K_RBRACE  = 6'd3;
    localparam logic [5:0] K_COMMA   = 6'd4;
    localparam logic [5:0] K_DOT     = 6'd5;
    localparam logic [5:0] K_MINUS   = 6'd6;
    localparam logic [5:0] K_PLUS    = 6'd7;
    localparam logic [5:0] K_SEMI    = 6'd8;
    localparam logic [5:0] K_SLASH   = 6'd9;
    localparam logic [5:0] K_STAR    = 6'd10;
    localparam logic [5:0] K_BANG    = 6'd11;
    localparam logic [5:0] K_EQUAL   = 6'd13;
    localparam logic [5:0] K_GREATER = 6'd15;
    localparam logic [5:0] K_LESS    = 6'd17;
    localparam logic [5:0] K_IDENT   = 6'd19;
    localparam logic [5:0] K_STRING  = 6'd20;
    localparam logic [5:0] K_NUMBER  = 6'd21;
    localparam logic [5:0] K_KW_BASE = 6'd22;
    localparam logic [5:0] K_ERROR   = 6'd38;
    localparam logic [5:0] K_EOF     = 6'd39;

    // Error codes
    localparam logic [1:0] E_NONE  = 2'd0;
    localparam logic [1:0] E_UNTERM = 2'd1;
    localparam logic [1:0] E_UNEXP = 2'd2;

    // Character codes
    localparam logic [7:0] C_NUL   = 8'h00;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_BANG  = 8'h21;
    localparam logic [7:0] C_QUOTE = 8'h22;
    localparam logic [7:0] C_LPAR  = 8'h28;
    localparam logic [7:0] C_RPAR  = 8'h29;
    localparam logic [7:0] C_STAR  = 8'h2A;
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_COMMA = 8'h2C;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_DOT   = 8'h2E;
    localparam logic [7:0] C_SLASH = 8'h2F;
    localparam logic [7:0] C_SEMI  = 8'h3B;
    localparam logic [7:0] C_LT    = 8'h3C;
    localparam logic [7:0] C_EQ    = 8'h3D;
    localparam logic [7:0] C_GT    = 8'h3E;
    localparam logic [7:0] C_UNDER = 8'h5F;
    localparam logic [7:0] C_LBRC  = 8'h7B;
    localparam logic [7:0] C_RBRC  = 8'h7D;

    // Most tokens one source byte can release
    localparam int MAX_TOKENS = 3;
    // Bundles held between scanner and output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS = 2;
    // Characters compared for keywords
    localparam int KW_CMP = 6;

    // Keyword text, first character in the top byte
    localparam logic [47:0] KW_TEXT [16] = '{
        {"and", 24'd0}, {"class", 8'd0}, {"else", 16'd0}, {"false", 8'd0},
        {"for", 24'd0}, {"fun", 24'd0}, {"if", 32'd0}, {"nil", 24'd0},
        {"or", 32'd0}, {"print", 8'd0}, "return", {"super", 8'd0},
        {"this", 16'd0}, {"true", 16'd0}, {"var", 24'd0}, {"while", 8'd0}
    };
    localparam logic [2:0] KW_LEN [16] = '{
        3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3,
        3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
    };

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == C_UNDER;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Keyword match on the stored prefix; identifier if none matches
    function automatic logic [5:0] kw_kind(input logic [47:0] chars,
                                           input logic [2:0] len);
        logic [5:0] kind;
        logic       hit;
        kind = K_IDENT;
        for (int k = 0; k < 16; k++)
        begin
            hit = (KW_LEN[k] == len);
            for (int i = 0; i < KW_CMP; i++)
            begin
                if (i < int'(len) && chars[47 - 8*i -: 8] != KW_TEXT[k][47 - 8*i -: 8])
                    hit = 1'b0;
            end
            if (hit && kind == K_IDENT)
                kind = K_KW_BASE + 6'(k);
        end
        return kind;
    endfunction

endpackage

### src/tlex_front.sv
// ============================================================================
// tlex_front
// Byte scanner: takes one source byte per cycle unless the queue is full,
// tracks the lexer mode and counters, and hands the tokens each byte releases
// (up to three) to the queue as one bundle; a byte with none pushes nothing.
// ============================================================================
module tlex_front #(
    parameter int OFFSET_BITS   = 24,
    parameter int LINE_BITS     = 16,
    parameter int LENGTH_BITS   = 16,
    parameter int KEYWORD_CHARS = 6,
    parameter int TOK_W         = 8 + OFFSET_BITS + LENGTH_BITS + LINE_BITS,
    parameter int BUN_W         = 2 + tlex_pkg::MAX_TOKENS * TOK_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [7:0]           char_code,
    output logic                 in_stall,
    input  tlex_pkg::fifo_stat_t q_stat,
    output logic                 push,
    output logic [BUN_W-1:0]     bundle
);
    localparam int PIDX = $clog2(KEYWORD_CHARS);
    localparam logic [LENGTH_BITS-1:0] RUN_MAX = {LENGTH_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] LEN1 = LENGTH_BITS'(1);
    localparam logic [LENGTH_BITS-1:0] LEN2 = LENGTH_BITS'(2);

    tlex_pkg::mode_t          mode_reg, mode_next;
    logic [OFFSET_BITS-1:0]   pos_reg, pos_next;
    logic [OFFSET_BITS-1:0]   begin_reg, begin_next;
    logic [LINE_BITS-1:0]     line_reg, line_next;
    logic [LENGTH_BITS-1:0]   run_reg, run_next;
    logic [7:0]               prefix_reg [KEYWORD_CHARS];

    logic                     accept;
    logic                     pfx_we;
    logic [PIDX-1:0]          pfx_idx;
    logic [TOK_W-1:0]         tok [tlex_pkg::MAX_TOKENS];
    logic [1:0]               n_tok;
    logic                     do_idle;
    logic                     saw_end;
    logic [LENGTH_BITS-1:0]   run_inc, run_inc2;
    logic [LINE_BITS-1:0]     line_inc;
    logic [47:0]              pfx_word;
    logic [5:0]               ident_kind;
    logic [5:0]               op_kind;

    function automatic logic [TOK_W-1:0] mk_tok(input logic [5:0] k,
                                                input logic [1:0] e,
                                                input logic [OFFSET_BITS-1:0] s,
                                                input logic [LENGTH_BITS-1:0] l,
                                                input logic [LINE_BITS-1:0] ln);
        return {k, e, s, l, ln};
    endfunction

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !in_stall;
    assign push     = accept && (n_tok != 2'd0);
    assign bundle   = {tok[2], tok[1], tok[0], n_tok};

    // Saturating counters
    assign run_inc  = (run_reg == RUN_MAX) ? run_reg : run_reg + LEN1;
    assign run_inc2 = (run_reg >= RUN_MAX - LEN1) ? RUN_MAX : run_reg + LEN2;
    assign line_inc = (line_reg == LINE_MAX) ? line_reg : line_reg + LINE_BITS'(1);

    // Keyword compare on the first six stored characters
    always_comb
    begin
        for (int i = 0; i < tlex_pkg::KW_CMP; i++)
            pfx_word[47 - 8*i -: 8] = prefix_reg[i];
        if (run_reg <= LENGTH_BITS'(tlex_pkg::KW_CMP))
            ident_kind = tlex_pkg::kw_kind(pfx_word, run_reg[2:0]);
        else
            ident_kind = tlex_pkg::K_IDENT;
    end

    // Pending operator kind
    always_comb
    begin
        case (mode_reg)
            tlex_pkg::M_BANG: op_kind = tlex_pkg::K_BANG;
            tlex_pkg::M_EQ:   op_kind = tlex_pkg::K_EQUAL;
            tlex_pkg::M_GT:   op_kind = tlex_pkg::K_GREATER;
            default:          op_kind = tlex_pkg::K_LESS;
        endcase
    end

    // Scanner next state and token emission
    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg + OFFSET_BITS'(1);
        begin_next = begin_reg;
        line_next  = line_reg;
        run_next   = run_reg;
        pfx_we     = 1'b0;
        pfx_idx    = run_reg[PIDX-1:0];
        do_idle    = 1'b0;
        saw_end    = 1'b0;
        n_tok      = 2'd0;
        for (int i = 0; i < tlex_pkg::MAX_TOKENS; i++)
            tok[i] = '0;

        // Mode-specific handling of the byte
        case (mode_reg)
            tlex_pkg::M_IDENT:
            begin
                if (tlex_pkg::is_alpha(char_code) || tlex_pkg::is_digit(char_code))
                begin
                    pfx_we   = (run_reg < LENGTH_BITS'(KEYWORD_CHARS));
                    run_next = run_inc;
                end
                else
                begin
                    tok[n_tok] = mk_tok(ident_kind, tlex_pkg::E_NONE, begin_reg,
                                        run_reg, line_reg);
                    n_tok = n_tok + 2'd1;
                    do_idle = 1'b1;
                end
            end
            tlex_pkg::M_INT:
            begin
                if (tlex_pkg::is_digit(char_code))
                    run_next = run_inc;
                else if (char_code == tlex_pkg::C_DOT)
                    mode_next = tlex_pkg::M_DOT;
                else
                begin
                    tok[n_tok] = mk_tok(tlex_pkg::K_NUMBER, tlex_pkg::E_NONE,
                                        begin_reg, run_reg, line_reg);
                    n_tok = n_tok + 2'd1;
                    do_idle = 1'b1;
                end
            end
            tlex_pkg::M_DOT:
            begin
                if (tlex_pkg::is_digit(char_code))
                begin
                    run_next  = run_inc2;
                    mode_next = tlex_pkg::M_FRAC;
                end
                else
                begin
                    tok[n_tok] = mk_tok(tlex_pkg::K_NUMBER, tlex_pkg::E_NONE,
                                        begin_reg, run_reg, line_reg);
                    n_tok = n_tok + 2'd1;
                    tok[n_tok] = mk_tok(tlex_pkg::K_DOT, tlex_pkg::E_NONE,
                                        pos_reg - OFFSET_BITS'(1), LEN1, line_reg);
                    n_tok = n_tok + 2'd1;
                    do_idle = 1'b1;
                end
            end
            tlex_pkg::M_FRAC:
            begin
                if (tlex_pkg::is_digit(char_code))
                    run_next = run_inc;
                else
                begin
                    tok[n_tok] = mk_tok(tlex_pkg::K_NUMBER, tlex_pkg::E_NONE,
                                        begin_reg, run_reg, line_reg);
                    n_tok = n_tok + 2'd1;
                    do_idle = 1'b1;
                end
            end
            tlex_pkg::M_STR:
            begin
                if (char_code == tlex_pkg::C_NUL)
                begin
                    tok[n_tok] = mk_tok(tlex_pkg::K_ERROR, tlex_pkg::E_UNTERM,
                                        begin_reg, run_reg, line_reg);
                    n_tok = n_tok + 2'd1;
                    do_idle = 1'b1;
                end
                else if (char_code == tlex_pkg::C_QUOTE)
                begin
                    run_next = run_inc;
                    tok[n_tok] = mk_tok(tlex_pkg::K_STRING, tlex_pkg::E_NONE,
                                        begin_reg, run_inc, line_reg);
                    n_tok = n_tok + 2'd1;
                    mode_next = tlex_pkg::M_IDLE;
                end
                else
                begin
                    if (char_code == tlex_pkg::C_LF)
                        line_next = line_inc;
                    run_next = run_inc;
                end
            end
            tlex_pkg::M_CMT:
            begin
                if (char_code == tlex_pkg::C_LF || char_code == tlex_pkg::C_NUL)
                    do_idle = 1'b1;
            end
            tlex_pkg::M_SLASH:
            begin
                if (char_code == tlex_pkg::C_SLASH)
                    mode_next = tlex_pkg::M_CMT;
                else
                begin
                    tok[n_tok] = mk_tok(tlex_pkg::K_SLASH, tlex_pkg::E_NONE,
                                        begin_reg, LEN1, line_reg);
                    n_tok = n_tok + 2'd1;
                    do_idle = 1'b1;
                end
            end
            tlex_pkg::M_BANG, tlex_pkg::M_EQ, tlex_pkg::M_GT, tlex_pkg::M_LT:
            begin
                if (char_code == tlex_pkg::C_EQ)
                begin
                    tok[n_tok] = mk_tok(op_kind + 6'd1, tlex_pkg::E_NONE,
                                        begin_reg, LEN2, line_reg);
                    n_tok = n_tok + 2'd1;
                    mode_next = tlex_pkg::M_IDLE;
                end
                else
                begin
                    tok[n_tok] = mk_tok(op_kind, tlex_pkg::E_NONE,
                                        begin_reg, LEN1, line_reg);
                    n_tok = n_tok + 2'd1;
                    do_idle = 1'b1;
                end
            end
            default:
                do_idle = 1'b1;
        endcase

        // Byte seen between tokens
        if (do_idle)
        begin
            mode_next = tlex_pkg::M_IDLE;
            case (char_code)
                tlex_pkg::C_SPACE, tlex_pkg::C_CR, tlex_pkg::C_TAB: ;
                tlex_pkg::C_LF:
                    line_next = line_inc;
                tlex_pkg::C_NUL:
                begin
                    tok[n_tok] = mk_tok(tlex_pkg::K_EOF, tlex_pkg::E_NONE, pos_reg,
                                        '0, line_reg);
                    n_tok = n_tok + 2'd1;
                    saw_end = 1'b1;
                end
                tlex_pkg::C_LPAR, tlex_pkg::C_RPAR, tlex_pkg::C_LBRC, tlex_pkg::C_RBRC,
                tlex_pkg::C_COMMA, tlex_pkg::C_DOT, tlex_pkg::C_MINUS, tlex_pkg::C_PLUS,
                tlex_pkg::C_SEMI, tlex_pkg::C_STAR:
                begin
                    case (char_code)
                        tlex_pkg::C_LPAR:  tok[n_tok] = mk_tok(tlex_pkg::K_LPAREN,
                                               tlex_pkg::E_NONE, pos_reg, LEN1, line_reg);
                        tlex_pkg::C_RPAR:  tok[n_tok] = mk_tok(tlex_pkg::K_RPAREN,
                                               tlex_pkg::E_NONE, pos_reg, LEN1, line_reg);
                        tlex_pkg::C_LBRC:  tok[n_tok] = mk_tok(tlex_pkg::K_LBRACE,
                                               tlex_pkg::E_NONE, pos_reg, LEN1, line_reg);
                        tlex_pkg::C_RBRC:  tok[n_tok] = mk_tok(tlex_pkg::K_RBRACE,
                                               tlex_pkg::E_NONE, pos_reg, LEN1, line_reg);
                        tlex_pkg::C_COMMA: tok[n_tok] = mk_tok(tlex_pkg::K_COMMA,
                                               tlex_pkg::E_NONE, pos_reg, LEN1, line_reg);
                        tlex_pkg::C_DOT:   tok[n_tok] = mk_tok(tlex_pkg::K_DOT,
                                               tlex_pkg::E_NONE, pos_reg, LEN1, line_reg);
                        tlex_pkg::C_MINUS: tok[n_tok] = mk_tok(tlex_pkg::K_MINUS,
                                               tlex_pkg::E_NONE, pos_reg, LEN1, line_reg);
                        tlex_pkg::C_PLUS:  tok[n_tok] = mk_tok(tlex_pkg::K_PLUS,
                                               tlex_pkg::E_NONE, pos_reg, LEN1, line_reg);
                        tlex_pkg::C_SEMI:  tok[n_tok] = mk_tok(tlex_pkg::K_SEMI,
                                               tlex_pkg::E_NONE, pos_reg, LEN1, line_reg);
                        default:           tok[n_tok] = mk_tok(tlex_pkg::K_STAR,
                                               tlex_pkg::E_NONE, pos_reg, LEN1, line_reg);
                    endcase
                    n_tok = n_tok + 2'd1;
                end
                tlex_pkg::C_SLASH, tlex_pkg::C_QUOTE, tlex_pkg::C_BANG,
                tlex_pkg::C_EQ, tlex_pkg::C_GT, tlex_pkg::C_LT:
                begin
                    case (char_code)
                        tlex_pkg::C_SLASH: mode_next = tlex_pkg::M_SLASH;
                        tlex_pkg::C_QUOTE: mode_next = tlex_pkg::M_STR;
                        tlex_pkg::C_BANG:  mode_next = tlex_pkg::M_BANG;
                        tlex_pkg::C_EQ:    mode_next = tlex_pkg::M_EQ;
                        tlex_pkg::C_GT:    mode_next = tlex_pkg::M_GT;
                        default:           mode_next = tlex_pkg::M_LT;
                    endcase
                    begin_next = pos_reg;
                    run_next   = LEN1;
                end
                default:
                begin
                    if (tlex_pkg::is_alpha(char_code))
                    begin
                        mode_next  = tlex_pkg::M_IDENT;
                        begin_next = pos_reg;
                        run_next   = LEN1;
                        pfx_we     = 1'b1;
                        pfx_idx    = '0;
                    end
                    else if (tlex_pkg::is_digit(char_code))
                    begin
                        mode_next  = tlex_pkg::M_INT;
                        begin_next = pos_reg;
                        run_next   = LEN1;
                    end
                    else
                    begin
                        tok[n_tok] = mk_tok(tlex_pkg::K_ERROR, tlex_pkg::E_UNEXP,
                                            pos_reg, LEN1, line_reg);
                        n_tok = n_tok + 2'd1;
                    end
                end
            endcase
        end

        // End of source: back to the reset state
        if (saw_end)
        begin
            mode_next  = tlex_pkg::M_IDLE;
            pos_next   = '0;
            begin_next = '0;
            line_next  = LINE_BITS'(1);
            run_next   = '0;
        end
    end

    // Scanner registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= tlex_pkg::M_IDLE;
            pos_reg   <= '0;
            begin_reg <= '0;
            line_reg  <= LINE_BITS'(1);
            run_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            begin_reg <= begin_next;
            line_reg  <= line_next;
            run_reg   <= run_next;
        end
    end

    // Identifier prefix store
    always_ff @(posedge clk)
    begin
        if (accept && pfx_we)
            prefix_reg[pfx_idx] <= char_code;
    end

endmodule

### src/tlex_queue.sv
// ============================================================================
// tlex_queue
// Short queue of token bundles between scanner and output stage.
// ============================================================================
module tlex_queue #(
    parameter int BUN_W = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [BUN_W-1:0]     push_data,
    input  logic                 pop,
    output logic [BUN_W-1:0]     head,
    output tlex_pkg::fifo_stat_t stat
);
    localparam int CNT_BITS = tlex_pkg::QPTR_BITS + 1;

    logic [BUN_W-1:0]                  mem_reg [tlex_pkg::QUEUE_DEPTH];
    logic [tlex_pkg::QPTR_BITS-1:0]    wr_reg, wr_next;
    logic [tlex_pkg::QPTR_BITS-1:0]    rd_reg, rd_next;
    logic [CNT_BITS-1:0]               cnt_reg, cnt_next;
    logic                              do_push, do_pop;

    assign stat.full  = (cnt_reg == CNT_BITS'(tlex_pkg::QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem_reg[rd_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + CNT_BITS'(do_push) - CNT_BITS'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Bundle storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_data;
    end

endmodule

### src/tlex_back.sv
// ============================================================================
// tlex_back
// Output stage: walks the head bundle's tokens one per cycle into the output
// register unless out_stall holds it; frees the bundle after its last token.
// ============================================================================
module tlex_back #(
    parameter int OFFSET_BITS = 24,
    parameter int LINE_BITS   = 16,
    parameter int LENGTH_BITS = 16,
    parameter int TOK_W       = 8 + OFFSET_BITS + LENGTH_BITS + LINE_BITS,
    parameter int BUN_W       = 2 + tlex_pkg::MAX_TOKENS * TOK_W
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [BUN_W-1:0]       head,
    input  tlex_pkg::fifo_stat_t   q_stat,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [5:0]             token_kind,
    output logic [1:0]             error_code,
    output logic [OFFSET_BITS-1:0] start_offset,
    output logic [LENGTH_BITS-1:0] lexeme_length,
    output logic [LINE_BITS-1:0]   line_number,
    output logic                   last_of_run
);
    logic                   valid_reg;
    logic [1:0]             idx_reg, idx_next;
    logic [TOK_W-1:0]       tok_reg;
    logic                   last_reg;
    logic                   load;
    logic                   is_last;
    logic [1:0]             head_cnt;
    logic [TOK_W-1:0]       cur_tok;

    assign head_cnt = head[1:0];
    assign cur_tok  = head[2 + TOK_W*idx_reg +: TOK_W];
    assign is_last  = (idx_reg + 2'd1 == head_cnt);
    assign load     = !q_stat.empty && (!valid_reg || !out_stall);
    assign pop      = load && is_last;

    // Token index within the head bundle
    always_comb
    begin
        if (load)
            idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
        else
            idx_next = idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
                valid_reg <= 1'b1;
            else if (!out_stall)
                valid_reg <= 1'b0;
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tok_reg  <= cur_tok;
            last_reg <= is_last;
        end
    end

    assign out_valid     = valid_reg;
    assign last_of_run   = last_reg;
    assign {token_kind, error_code, start_offset, lexeme_length, line_number} = tok_reg;

endmodule

### src/token_lexer.sv
// ============================================================================
// token_lexer
// Streaming lexer: one source byte in, tokens out.
// ============================================================================
// One byte is taken per cycle unless in_stall is set; the scanner classifies
// it combinationally, including the six-character keyword compare. A byte
// releases zero to three tokens, which go as one bundle into a four-deep
// queue; the output stage sends one token per cycle unless out_stall holds
// it, so the token rate sets the sustained throughput when bytes release
// more than one token. A token passes through the queue and the output
// register, with last_of_run set on the final token of that byte. Byte 0
// ends the source, yields the end-of-file token and resets the scanner.
module token_lexer #(
    parameter int OFFSET_BITS   = 24,
    parameter int LINE_BITS     = 16,
    parameter int LENGTH_BITS   = 16,
    parameter int KEYWORD_CHARS = 6
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             char_code,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [5:0]             token_kind,
    output logic [1:0]             error_code,
    output logic [OFFSET_BITS-1:0] start_offset,
    output logic [LENGTH_BITS-1:0] lexeme_length,
    output logic [LINE_BITS-1:0]   line_number,
    output logic                   last_of_run
);
    localparam int TOK_W = 8 + OFFSET_BITS + LENGTH_BITS + LINE_BITS;
    localparam int BUN_W = 2 + tlex_pkg::MAX_TOKENS * TOK_W;

    tlex_pkg::fifo_stat_t q_stat;
    logic                 push, pop;
    logic [BUN_W-1:0]     push_data, head;

    tlex_front #(
        .OFFSET_BITS   (OFFSET_BITS),
        .LINE_BITS     (LINE_BITS),
        .LENGTH_BITS   (LENGTH_BITS),
        .KEYWORD_CHARS (KEYWORD_CHARS),
        .TOK_W         (TOK_W),
        .BUN_W         (BUN_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .char_code (char_code),
        .in_stall  (in_stall),
        .q_stat    (q_stat),
        .push      (push),
        .bundle    (push_data)
    );

    tlex_queue #(
        .BUN_W (BUN_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    tlex_back #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS),
        .LENGTH_BITS (LENGTH_BITS),
        .TOK_W       (TOK_W),
        .BUN_W       (BUN_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_stat        (q_stat),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .token_kind    (token_kind),
        .error_code    (error_code),
        .start_offset  (start_offset),
        .lexeme_length (lexeme_length),
        .line_number   (line_number),
        .last_of_run   (last_of_run)
    );

endmodule
